// ----- design/sst_pkg.sv -----
// Shared types and constants for the semaphore set table.
// No dependencies; used by sst_cell, semaphore_set_table and semaphore_set_table_tb.
`timescale 1ns / 1ps

package sst_pkg;

	// default table geometry
	localparam int MAX_SETS_DEF         = 16;
	localparam int MAX_SEMS_PER_SET_DEF = 16;

	// largest value a semaphore may hold
	localparam logic [15:0] SEM_VALUE_MAX = 16'd32767;

	// action codes
	localparam logic [1:0] ACT_GET  = 2'd0;
	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_OP   = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EXISTS      = 3'd1;
	localparam logic [2:0] ST_INVALID     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [2:0] ST_WOULD_BLOCK = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;
	localparam logic [2:0] ST_RANGE       = 3'd6;

	// lookup request broadcast to every cell
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] id;
	} req_t;

	// slot contents written on creation
	typedef struct packed {
		logic [31:0] key;
		logic [15:0] id;
	} wr_t;

	// search record that moves one cell per cycle
	typedef struct packed {
		logic        active;
		logic        key_hit;
		logic        id_hit;
		logic        free_hit;
		logic [15:0] key_id;
	} scan_t;

endpackage

// ----- design/sst_cell.sv -----
// One slot of the set table: valid, key, id and size, plus one stage of the search chain.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell #(
	parameter int SLOT_W = 4,
	parameter int SIZE_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SLOT_W-1:0]   cell_slot,
	input  sst_pkg::req_t       req,
	input  logic                wr_en,
	input  sst_pkg::wr_t        wr,
	input  logic [SIZE_W-1:0]   wr_size,
	input  sst_pkg::scan_t      scan_in,
	input  logic [SIZE_W-1:0]   key_size_in,
	input  logic [SLOT_W-1:0]   id_slot_in,
	input  logic [SIZE_W-1:0]   id_size_in,
	input  logic [SLOT_W-1:0]   free_slot_in,
	output sst_pkg::scan_t      scan_out,
	output logic [SIZE_W-1:0]   key_size_out,
	output logic [SLOT_W-1:0]   id_slot_out,
	output logic [SIZE_W-1:0]   id_size_out,
	output logic [SLOT_W-1:0]   free_slot_out
);

	logic              valid_q;
	logic [31:0]       key_q;
	logic [15:0]       id_q;
	logic [SIZE_W-1:0] size_q;

	sst_pkg::scan_t    scan_d;
	logic [SIZE_W-1:0] key_size_d;
	logic [SLOT_W-1:0] id_slot_d;
	logic [SIZE_W-1:0] id_size_d;
	logic [SLOT_W-1:0] free_slot_d;

	// earlier cells win: only take a hit if none is recorded yet
	always_comb begin
		scan_d      = scan_in;
		key_size_d  = key_size_in;
		id_slot_d   = id_slot_in;
		id_size_d   = id_size_in;
		free_slot_d = free_slot_in;
		if (!scan_in.key_hit && valid_q && key_q == req.key) begin
			scan_d.key_hit = 1'b1;
			scan_d.key_id  = id_q;
			key_size_d     = size_q;
		end
		if (!scan_in.id_hit && valid_q && id_q == req.id) begin
			scan_d.id_hit = 1'b1;
			id_slot_d     = cell_slot;
			id_size_d     = size_q;
		end
		if (!scan_in.free_hit && !valid_q) begin
			scan_d.free_hit = 1'b1;
			free_slot_d     = cell_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			scan_out <= '0;
		end else begin
			scan_out <= scan_d;
			if (wr_en) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_size_out  <= key_size_d;
		id_slot_out   <= id_slot_d;
		id_size_out   <= id_size_d;
		free_slot_out <= free_slot_d;
		if (wr_en) begin
			key_q  <= wr.key;
			id_q   <= wr.id;
			size_q <= wr_size;
		end
	end

endmodule

// ----- design/sst_sem_ram.sv -----
// Single-port semaphore value memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sst_sem_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [15:0]       wdata,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- design/semaphore_set_table.sv -----
// Semaphore set table: get/create sets by key, read, write and operate on semaphores.
// Depends on sst_pkg, sst_cell, sst_sem_ram.
`timescale 1ns / 1ps

// Usage
//  Input channel (in_valid / in_stall): one request item per handshake, taken at a
//  rising edge with in_valid high and in_stall low. in_stall is high while an item is
//  in progress. Output channel (out_valid / out_stall): one result item (status,
//  result_value) per request, held in an output register until taken.
//  Each item first walks the row of slot cells, one cell per cycle, behind the launch
//  register. A get without creation then goes straight to the result; a get that creates
//  a set first clears its new semaphores, one memory word a cycle; set value, get value
//  and op do a read-modify-write on the single-port value memory.
//  The result enters the output register at the same edge as the block returns to idle.
//  A new item may be accepted while the previous result waits; if the receiver keeps
//  out_stall high, the block finishes the next item and then holds in_stall high
//  until the output register frees up.
//  Reset (arst_n low) empties the table and zeroes the id counter; no clearing pass
//  is needed since a set's semaphores are cleared when it is created.
module semaphore_set_table #(
	parameter int MAX_SETS         = sst_pkg::MAX_SETS_DEF,
	parameter int MAX_SEMS_PER_SET = sst_pkg::MAX_SEMS_PER_SET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [31:0]        set_key,
	input  logic [7:0]         count_requested,
	input  logic               create_flag,
	input  logic               exclusive_flag,
	input  logic [15:0]        set_handle,
	input  logic [7:0]         sem_index,
	input  logic [15:0]        new_value,
	input  logic signed [15:0] op_amount,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [15:0]        result_value
);

	localparam int SLOT_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SIZE_W    = $clog2(MAX_SEMS_PER_SET + 1);
	localparam int MEM_DEPTH = MAX_SETS * MAX_SEMS_PER_SET;
	localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int unsigned SEMS = MAX_SEMS_PER_SET;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_CLEAR  = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_MODIFY = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]  state_q;
	logic        launch_q;
	logic [15:0] id_counter_q;
	logic        out_valid_q;
	logic [SIZE_W-1:0] clr_cnt_q;

	// latched request
	logic [1:0]         act_q;
	logic [31:0]        key_q;
	logic [7:0]         count_q;
	logic               create_q;
	logic               excl_q;
	logic [15:0]        handle_q;
	logic [7:0]         idx_q;
	logic [15:0]        nval_q;
	logic signed [15:0] op_q;

	logic [ADDR_W-1:0] addr_q;
	logic [2:0]        res_status_q;
	logic [15:0]       res_value_q;
	logic [2:0]        status_q;
	logic [15:0]       value_q;

	logic accept;
	logic out_free;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------------------
	// Row of slot cells; the search record enters at cell 0 and leaves at the tail.
	// ---------------------------------------------------------------------------
	sst_pkg::scan_t    chain      [MAX_SETS+1];
	logic [SIZE_W-1:0] key_size_c [MAX_SETS+1];
	logic [SLOT_W-1:0] id_slot_c  [MAX_SETS+1];
	logic [SIZE_W-1:0] id_size_c  [MAX_SETS+1];
	logic [SLOT_W-1:0] free_slot_c[MAX_SETS+1];

	sst_pkg::req_t  req;
	sst_pkg::wr_t   wr;
	logic [SIZE_W-1:0] wr_size;
	logic [15:0]    new_id;
	logic           create_go;
	logic [MAX_SETS-1:0] wr_en;

	assign req     = '{key: key_q, id: handle_q};
	assign new_id  = id_counter_q + 16'd1;
	assign wr      = '{key: key_q, id: new_id};
	assign wr_size = SIZE_W'(count_q);

	always_comb begin
		chain[0]        = '0;
		chain[0].active = launch_q;
	end
	assign key_size_c[0]  = '0;
	assign id_slot_c[0]   = '0;
	assign id_size_c[0]   = '0;
	assign free_slot_c[0] = '0;

	sst_pkg::scan_t    tail;
	logic [SIZE_W-1:0] tail_key_size;
	logic [SLOT_W-1:0] tail_id_slot;
	logic [SIZE_W-1:0] tail_id_size;
	logic [SLOT_W-1:0] tail_free_slot;
	logic              scan_end;

	assign tail           = chain[MAX_SETS];
	assign tail_key_size  = key_size_c[MAX_SETS];
	assign tail_id_slot   = id_slot_c[MAX_SETS];
	assign tail_id_size   = id_size_c[MAX_SETS];
	assign tail_free_slot = free_slot_c[MAX_SETS];
	assign scan_end       = (state_q == S_SCAN) && tail.active;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_SETS; gi++) begin : g_cell
			assign wr_en[gi] = create_go && (tail_free_slot == SLOT_W'(gi));

			sst_cell #(
				.SLOT_W(SLOT_W),
				.SIZE_W(SIZE_W)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cell_slot    (SLOT_W'(gi)),
				.req          (req),
				.wr_en        (wr_en[gi]),
				.wr           (wr),
				.wr_size      (wr_size),
				.scan_in      (chain[gi]),
				.key_size_in  (key_size_c[gi]),
				.id_slot_in   (id_slot_c[gi]),
				.id_size_in   (id_size_c[gi]),
				.free_slot_in (free_slot_c[gi]),
				.scan_out     (chain[gi+1]),
				.key_size_out (key_size_c[gi+1]),
				.id_slot_out  (id_slot_c[gi+1]),
				.id_size_out  (id_size_c[gi+1]),
				.free_slot_out(free_slot_c[gi+1])
			);
		end
	endgenerate

	// ---------------------------------------------------------------------------
	// Decision once the search record reaches the tail.
	// ---------------------------------------------------------------------------
	logic [2:0]  dec_status;
	logic [15:0] dec_value;
	logic        dec_create;
	logic        dec_access;
	logic        key_nz;
	logic        key_found;
	logic [ADDR_W-1:0] acc_addr;
	logic [ADDR_W-1:0] clr_addr;

	assign key_nz    = (key_q != 32'd0);
	assign key_found = key_nz && tail.key_hit;
	assign acc_addr  = ADDR_W'(tail_id_slot * SEMS) + ADDR_W'(idx_q);
	assign clr_addr  = ADDR_W'(tail_free_slot * SEMS);
	assign create_go = scan_end && dec_create;

	always_comb begin
		dec_status = sst_pkg::ST_OK;
		dec_value  = 16'd0;
		dec_create = 1'b0;
		dec_access = 1'b0;
		if (act_q == sst_pkg::ACT_GET) begin
			if (create_q && excl_q && key_found) begin
				dec_status = sst_pkg::ST_EXISTS;
			end else if (key_nz && !create_q && !key_found) begin
				dec_status = sst_pkg::ST_NOT_FOUND;
			end else if (key_found) begin
				// existing set: requested count must fit
				if ({1'b0, count_q} > 9'(tail_key_size)) begin
					dec_status = sst_pkg::ST_INVALID;
				end else begin
					dec_value = tail.key_id;
				end
			end else if (count_q == 8'd0 || {1'b0, count_q} > 9'(MAX_SEMS_PER_SET)) begin
				dec_status = sst_pkg::ST_INVALID;
			end else if (!tail.free_hit) begin
				dec_status = sst_pkg::ST_FULL;
			end else begin
				dec_create = 1'b1;
				dec_value  = new_id;
			end
		end else begin
			if (!tail.id_hit || {1'b0, idx_q} >= 9'(tail_id_size)) begin
				dec_status = sst_pkg::ST_INVALID;
			end else begin
				dec_access = 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------
	// Value memory and read-modify-write
	// ---------------------------------------------------------------------------
	logic        ram_we;
	logic        ram_re;
	logic [15:0] ram_wdata;
	logic [15:0] rd_data;

	logic signed [17:0] sum;
	logic [2:0]  mod_status;
	logic [15:0] mod_value;
	logic        mod_write;
	logic [15:0] mod_wdata;

	assign sum = $signed({2'b00, rd_data}) + 18'(op_q);

	always_comb begin
		mod_status = sst_pkg::ST_OK;
		mod_value  = 16'd0;
		mod_write  = 1'b0;
		mod_wdata  = sum[15:0];
		case (act_q)
			sst_pkg::ACT_SET: begin
				mod_wdata = nval_q;
				if (nval_q > sst_pkg::SEM_VALUE_MAX) begin
					mod_status = sst_pkg::ST_RANGE;
				end else begin
					mod_write = 1'b1;
				end
			end
			sst_pkg::ACT_READ: begin
				mod_value = rd_data;
			end
			sst_pkg::ACT_OP: begin
				if (op_q > 16'sd0) begin
					if (sum > $signed({2'b00, sst_pkg::SEM_VALUE_MAX})) begin
						mod_status = sst_pkg::ST_RANGE;
					end else begin
						mod_write = 1'b1;
					end
				end else if (op_q < 16'sd0) begin
					// take only if enough remains
					if (sum < 18'sd0) begin
						mod_status = sst_pkg::ST_WOULD_BLOCK;
					end else begin
						mod_write = 1'b1;
					end
				end else if (rd_data != 16'd0) begin
					// wait for zero is never held
					mod_status = sst_pkg::ST_WOULD_BLOCK;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_re    = (state_q == S_READ);
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_MODIFY) && mod_write);
	assign ram_wdata = (state_q == S_CLEAR) ? 16'd0 : mod_wdata;

	sst_sem_ram #(
		.DEPTH (MEM_DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (addr_q),
		.wdata(ram_wdata),
		.rdata(rd_data)
	);

	// ---------------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launch_q     <= 1'b0;
			id_counter_q <= 16'd0;
			out_valid_q  <= 1'b0;
			clr_cnt_q    <= '0;
		end else begin
			launch_q <= accept;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tail.active) begin
						if (dec_create) begin
							id_counter_q <= new_id;
							clr_cnt_q    <= SIZE_W'(count_q);
							state_q      <= S_CLEAR;
						end else if (dec_access) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q - 1'b1;
					if (clr_cnt_q == SIZE_W'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action;
			key_q    <= set_key;
			count_q  <= count_requested;
			create_q <= create_flag;
			excl_q   <= exclusive_flag;
			handle_q <= set_handle;
			idx_q    <= sem_index;
			nval_q   <= new_value;
			op_q     <= op_amount;
		end
		if (scan_end) begin
			res_status_q <= dec_status;
			res_value_q  <= dec_value;
			addr_q       <= dec_create ? clr_addr : acc_addr;
		end
		if (state_q == S_CLEAR) begin
			addr_q <= addr_q + 1'b1;
		end
		if (state_q == S_MODIFY) begin
			res_status_q <= mod_status;
			res_value_q  <= mod_value;
		end
		if (state_q == S_DONE && out_free) begin
			status_q <= res_status_q;
			value_q  <= res_value_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_value = value_q;

endmodule

// ----- test/semaphore_set_table_tb.sv -----
// Self-checking testbench for semaphore_set_table: a directed script, then random traffic.
// Depends on sst_pkg and the semaphore_set_table RTL; checked against a local predictor.
`timescale 1ns / 1ps

module semaphore_set_table_tb;

	localparam int NSETS     = sst_pkg::MAX_SETS_DEF;
	localparam int NSEMS     = sst_pkg::MAX_SEMS_PER_SET_DEF;
	localparam int NDIR      = 27;
	localparam int NRAND     = 1625;
	localparam int HOLD_LEN  = 300;   // long receiver hold-off, in cycles
	localparam int DRAIN_LEN = 60;    // idle wait after the last reply is checked

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        key;
		logic [7:0]         count;
		logic               create;
		logic               excl;
		logic [15:0]        handle;
		logic [7:0]         idx;
		logic [15:0]        nval;
		logic signed [15:0] amount;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] value;
	} sem_reply_t;

	// one script row; pinned rows carry a hand-written reply
	typedef struct packed {
		req_item_t  req;
		logic       pinned;
		sem_reply_t reply;
	} dir_row_t;

	logic               clk;
	logic               arst_n          = 1'b0;
	logic               in_valid        = 1'b0;
	logic               in_stall;
	logic [1:0]         action          = sst_pkg::ACT_GET;
	logic [31:0]        set_key         = '0;
	logic [7:0]         count_requested = '0;
	logic               create_flag     = 1'b0;
	logic               exclusive_flag  = 1'b0;
	logic [15:0]        set_handle      = '0;
	logic [7:0]         sem_index       = '0;
	logic [15:0]        new_value       = '0;
	logic signed [15:0] op_amount       = '0;
	logic               out_valid;
	logic               out_stall       = 1'b0;
	logic [2:0]         status;
	logic [15:0]        result_value;

	// shadow copy of the table
	bit          tbl_valid [NSETS];
	logic [31:0] tbl_key   [NSETS];
	logic [15:0] tbl_id    [NSETS];
	int          tbl_size  [NSETS];
	logic [15:0] sem_val   [NSETS*NSEMS];
	logic [15:0] last_id;

	sem_reply_t replies_due [$];
	int         mismatches    = 0;
	int         results_taken = 0;
	bit         steady        = 1'b0;   // no idling on either side while set
	bit         held_off      = 1'b0;

	dir_row_t script_rows [NDIR] = '{
		// empty table: nothing to address, nothing to find
		'{'{sst_pkg::ACT_READ, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		'{'{sst_pkg::ACT_GET, 32'h5, 8'd1, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_NOT_FOUND, 16'd0}},
		// bad counts on create
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd0, 1'b1, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd17, 1'b1, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd255, 1'b1, 1'b1, 16'hFFFF, 8'd255, 16'hFFFF, 16'sh7FFF},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		// create, then exclusive conflict, then plain lookup and an oversized request
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd16, 1'b1, 1'b1, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd1}},
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd1, 1'b1, 1'b1, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_EXISTS, 16'd0}},
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd16, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd1}},
		'{'{sst_pkg::ACT_GET, 32'hFFFF_FFFF,
			8'd17, 1'b1, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		// private key creates even without the create flag
		'{'{sst_pkg::ACT_GET, 32'h0, 8'd1, 1'b0, 1'b0, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd2}},
		'{'{sst_pkg::ACT_GET, 32'h0, 8'd16, 1'b1, 1'b1, 16'd0, 8'd0, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd3}},
		// value limits on set 1, top index
		'{'{sst_pkg::ACT_SET, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd32767, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_SET, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd32768, 16'sd0},
			1'b1, '{sst_pkg::ST_RANGE, 16'd0}},
		'{'{sst_pkg::ACT_SET, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'hFFFF, 16'sd0},
			1'b1, '{sst_pkg::ST_RANGE, 16'd0}},
		'{'{sst_pkg::ACT_READ, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd32767}},
		// overflow, not enough, drain to zero, wait for zero both ways with a refill between
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sd1},
			1'b1, '{sst_pkg::ST_RANGE, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sh8000},
			1'b1, '{sst_pkg::ST_WOULD_BLOCK, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, -16'sd32767},
			1'b1, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sh7FFF},
			1'b1, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd1, 8'd15, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_WOULD_BLOCK, 16'd0}},
		// bad index, unknown id
		'{'{sst_pkg::ACT_READ, 32'h0, 8'd0, 1'b0, 1'b0, 16'd2, 8'd1, 16'd0, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'hFFFF, 8'd0, 16'd0, -16'sd1},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		'{'{sst_pkg::ACT_SET, 32'h0, 8'd0, 1'b0, 1'b0, 16'd3, 8'd255, 16'd5, 16'sd0},
			1'b1, '{sst_pkg::ST_INVALID, 16'd0}},
		// left to the predictor
		'{'{sst_pkg::ACT_SET, 32'h0, 8'd0, 1'b0, 1'b0, 16'd3, 8'd0, 16'd1234, 16'sd0},
			1'b0, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_OP, 32'h0, 8'd0, 1'b0, 1'b0, 16'd3, 8'd0, 16'd0, -16'sd34},
			1'b0, '{sst_pkg::ST_OK, 16'd0}},
		'{'{sst_pkg::ACT_READ, 32'h0, 8'd0, 1'b0, 1'b0, 16'd3, 8'd0, 16'd0, 16'sd0},
			1'b0, '{sst_pkg::ST_OK, 16'd0}}
	};

	semaphore_set_table DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.set_key         (set_key),
		.count_requested (count_requested),
		.create_flag     (create_flag),
		.exclusive_flag  (exclusive_flag),
		.set_handle      (set_handle),
		.sem_index       (sem_index),
		.new_value       (new_value),
		.op_amount       (op_amount),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.result_value    (result_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one accepted request to the shadow table and returns its reply.
	function automatic sem_reply_t semaphore_reply(req_item_t r);
		sem_reply_t res;
		int slot, s, p, v, a;
		res.status = sst_pkg::ST_OK;
		res.value = '0;
		slot = -1;
		if (r.action == sst_pkg::ACT_GET) begin
			if (r.key != '0)
				for (s = NSETS - 1; s >= 0; s--)
					if (tbl_valid[s] && tbl_key[s] == r.key) slot = s;
			if (r.create && r.excl && slot >= 0)
				res.status = sst_pkg::ST_EXISTS;
			else if (r.key != '0 && !r.create && slot < 0)
				res.status = sst_pkg::ST_NOT_FOUND;
			else if (r.key != '0 && slot >= 0) begin
				if (int'(r.count) > tbl_size[slot]) res.status = sst_pkg::ST_INVALID;
				else res.value = tbl_id[slot];
			end else if (r.count == '0 || int'(r.count) > NSEMS) begin
				res.status = sst_pkg::ST_INVALID;
			end else begin
				// lowest free slot takes the new set
				for (s = NSETS - 1; s >= 0; s--)
					if (!tbl_valid[s]) slot = s;
				if (slot < 0) begin
					res.status = sst_pkg::ST_FULL;
				end else begin
					last_id = last_id + 16'd1;
					tbl_valid[slot] = 1'b1;
					tbl_key[slot] = r.key;
					tbl_id[slot] = last_id;
					tbl_size[slot] = int'(r.count);
					for (s = 0; s < NSEMS; s++) sem_val[slot*NSEMS + s] = '0;
					res.value = last_id;
				end
			end
		end else begin
			for (s = NSETS - 1; s >= 0; s--)
				if (tbl_valid[s] && tbl_id[s] == r.handle) slot = s;
			if (slot < 0 || int'(r.idx) >= tbl_size[slot]) begin
				res.status = sst_pkg::ST_INVALID;
			end else begin
				p = slot*NSEMS + int'(r.idx);
				v = int'(sem_val[p]);
				a = int'($signed(r.amount));
				case (r.action)
					sst_pkg::ACT_SET: begin
						if (r.nval > sst_pkg::SEM_VALUE_MAX) res.status = sst_pkg::ST_RANGE;
						else sem_val[p] = r.nval;
					end
					sst_pkg::ACT_READ: begin
						res.value = sem_val[p];
					end
					default: begin
						if (a > 0) begin
							if (v + a > int'(sst_pkg::SEM_VALUE_MAX))
								res.status = sst_pkg::ST_RANGE;
							else sem_val[p] = 16'(v + a);
						end else if (a < 0) begin
							if (v < -a) res.status = sst_pkg::ST_WOULD_BLOCK;
							else sem_val[p] = 16'(v + a);
						end else if (v != 0) begin
							res.status = sst_pkg::ST_WOULD_BLOCK;
						end
					end
				endcase
			end
		end
		return res;
	endfunction

	// Random request, mostly aimed at live sets with in-range indexes and values.
	function automatic req_item_t pick_request();
		req_item_t r;
		int roll, slot, live, s;
		r.action = sst_pkg::ACT_GET;
		r.key = $urandom();
		r.count = 8'($urandom());
		r.create = 1'($urandom());
		r.excl = 1'($urandom());
		r.handle = 16'($urandom());
		r.idx = 8'($urandom());
		r.nval = 16'($urandom());
		r.amount = 16'($urandom());
		// uniform pick among live sets
		live = 0;
		slot = -1;
		for (s = 0; s < NSETS; s++)
			if (tbl_valid[s]) begin
				live++;
				if ($urandom_range(live - 1) == 0) slot = s;
			end
		roll = $urandom_range(99);
		if (roll < 25) begin
			roll = $urandom_range(99);
			if (roll < 55 && slot >= 0) r.key = tbl_key[slot];
			else if (roll < 70) r.key = '0;
			r.create = ($urandom_range(99) < 60);
			r.excl = ($urandom_range(99) < 25);
			roll = $urandom_range(99);
			if (roll < 80) r.count = 8'($urandom_range(1, NSEMS));
			else if (roll < 88) r.count = '0;
		end else begin
			r.action = (roll < 45) ? sst_pkg::ACT_SET :
				(roll < 65) ? sst_pkg::ACT_READ : sst_pkg::ACT_OP;
			if (slot >= 0 && $urandom_range(99) < 90) begin
				r.handle = tbl_id[slot];
				if ($urandom_range(99) < 92) r.idx = 8'($urandom_range(0, tbl_size[slot] - 1));
			end
			roll = $urandom_range(99);
			if (roll < 85) r.nval = 16'($urandom_range(0, 32767));
			else if (roll < 93) r.nval = 16'($urandom_range(32760, 32767));
			roll = $urandom_range(99);
			if (roll < 40) r.amount = 16'($urandom_range(1, 64));
			else if (roll < 80) r.amount = 16'(0 - $urandom_range(1, 64));
			else if (roll < 88) r.amount = '0;
		end
		return r;
	endfunction

	// Offers one item, waits for the handshake, then books its reply.
	task automatic offer(req_item_t r, bit pinned, sem_reply_t typed);
		sem_reply_t predicted;
		while (!steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		action          <= r.action;
		set_key         <= r.key;
		count_requested <= r.count;
		create_flag     <= r.create;
		exclusive_flag  <= r.excl;
		set_handle      <= r.handle;
		sem_index       <= r.idx;
		new_value       <= r.nval;
		op_amount       <= r.amount;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = semaphore_reply(r);
		replies_due.push_back(pinned ? typed : predicted);
	endtask

	initial begin : stimulus
		int n, s;
		for (s = 0; s < NSETS; s++) begin
			tbl_valid[s] = 1'b0;
			tbl_key[s] = '0;
			tbl_id[s] = '0;
			tbl_size[s] = 0;
		end
		for (s = 0; s < NSETS*NSEMS; s++) sem_val[s] = '0;
		last_id = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (n = 0; n < NDIR; n++)
			offer(script_rows[n].req, script_rows[n].pinned, script_rows[n].reply);
		for (n = 0; n < NRAND; n++) begin
			steady = (n >= 700 && n < 1000);
			offer(pick_request(), 1'b0, '0);
		end
		steady = 1'b0;
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (DRAIN_LEN) @(posedge clk);
		if (mismatches == 0)
			$display("semaphore_set_table_tb: done, clean");
		else
			$display("semaphore_set_table_tb: done, errors");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin : result_sink
		int hold;
		forever begin
			@(posedge clk);
			if (!held_off && results_taken >= 400) begin
				held_off = 1'b1;
				out_stall <= 1'b1;
				for (hold = 0; hold < HOLD_LEN; hold++) @(posedge clk);
			end else begin
				out_stall <= (!steady && $urandom_range(99) < 9);
			end
		end
	end

	always @(posedge clk) begin : reply_check
		sem_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: reply with none due: status %0d value %0d",
					$time, status, result_value);
			end else begin
				want = replies_due.pop_front();
				if (status !== want.status) begin
					mismatches++;
					$display("%0t: status expected %0d, got %0d", $time, want.status, status);
				end
				if (result_value !== want.value) begin
					mismatches++;
					$display("%0t: result_value expected %0d, got %0d",
						$time, want.value, result_value);
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("semaphore_set_table_tb: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sst_pkg.sv
design/sst_cell.sv
design/sst_sem_ram.sv
design/semaphore_set_table.sv
test/semaphore_set_table_tb.sv
